>>> src/tctb_pkg.sv
// ----------------------------------------------------------------------------
// tctb_pkg
// Shared types and constants of the character-cell terminal buffer: the
// request and response payloads, command and control byte codes, register
// indexes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tctb_pkg;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_NUL       = 8'd0;

   localparam logic [8:0] TAB_STEP = 9'd4;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [5:0] ROWS_RESET    = 6'd25;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [4:0] cursor_row_now;
      logic [7:0] cursor_col_now;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic copy_step;
      logic fill_step;
      logic put_write;
      logic capture_cell;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_clear;
      logic tab_fill;
      logic need_scroll;
      logic scroll_copy;
      logic wrap_put;
      logic walk_last;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/tctb_ctrl.sv
// ----------------------------------------------------------------------------
// tctb_ctrl
// Sequencer of the terminal buffer: accepts requests, steps the datapath
// through the cell walks of a command and hands over the response.
// ----------------------------------------------------------------------------
`default_nettype none

module tctb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire tctb_pkg::dp_status_type status,
   output tctb_pkg::ctl_cmd_type       cmd
);
   import tctb_pkg::*;

   typedef enum logic [7:0] {
      ST_INIT = 8'b0000_0001,
      ST_IDLE = 8'b0000_0010,
      ST_EXEC = 8'b0000_0100,
      ST_COPY = 8'b0000_1000,
      ST_FILL = 8'b0001_0000,
      ST_PUT  = 8'b0010_0000,
      ST_READ = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_put_ff, pend_put_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pend_put_in  = pend_put_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec    = 1'b1;
            pend_put_in = status.wrap_put;
            if (status.is_read) begin
               state_in = ST_READ;
            end else if (status.is_clear || status.tab_fill) begin
               state_in = ST_FILL;
            end else if (status.need_scroll) begin
               state_in = status.scroll_copy ? ST_COPY : ST_FILL;
            end else if (status.wrap_put) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.walk_last) begin
               state_in = pend_put_ff ? ST_PUT : ST_DONE;
            end
         end
         ST_PUT: begin
            cmd.put_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_READ: begin
            cmd.capture_cell = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               req_stall    = 1'b0;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         pend_put_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_put_ff  <= pend_put_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/tctb_dp.sv
// ----------------------------------------------------------------------------
// tctb_dp
// Datapath of the terminal buffer: cell memory with a registered read port
// and a staged write port, cursor, configuration registers, cell walker and
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tctb_dp #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_LINES   = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire tctb_pkg::req_type      req_data,
   output tctb_pkg::rsp_type           rsp_data,
   input  wire tctb_pkg::ctl_cmd_type  cmd,
   output tctb_pkg::dp_status_type     status
);
   import tctb_pkg::*;

   localparam int COL_AW = $clog2(MAX_COLUMNS);
   localparam int ROW_AW = $clog2(MAX_LINES);
   localparam int ADDR_W = ROW_AW + COL_AW;
   localparam int DEPTH  = MAX_LINES * (2 ** COL_AW);

   logic [7:0] mem [DEPTH];

   logic [7:0]        cols_cfg_ff, cols_cfg_in;
   logic [5:0]        rows_cfg_ff, rows_cfg_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [7:0]        col_ff, col_in;
   req_type           req_ff, req_in;

   logic [ROW_AW-1:0] wk_row_ff, wk_row_in;
   logic [COL_AW-1:0] wk_col_ff, wk_col_in;
   logic [ROW_AW-1:0] wk_last_row_ff, wk_last_row_in;
   logic [COL_AW-1:0] wk_last_col_ff, wk_last_col_in;
   logic [7:0]        wk_val_ff, wk_val_in;

   logic              wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              wr_src_rd_ff, wr_src_rd_in;
   logic [7:0]        wr_data_ff, wr_data_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_ff;

   logic [7:0] cell_ff, cell_in;
   logic       rd_ok_ff, rd_ok_in;
   rsp_type    rsp_ff, rsp_in;

   logic [7:0]        eff_cols;
   logic [5:0]        eff_rows;
   logic [COL_AW-1:0] cols_last;
   logic [ROW_AW-1:0] rows_last;
   logic              is_put, is_clear, is_read;
   logic              ch_nl, ch_cr, ch_bs, ch_tab, ch_ord;
   logic              col_full, nl_now, scroll_now, multi_row, walk_last;
   logic [7:0]        row_inc;
   logic [8:0]        tab_base;
   logic [7:0]        tab_end;

   assign csr_ready = 1'b1;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (cols_cfg_ff == 8'd0) begin
         eff_cols = 8'd1;
      end else if (32'(cols_cfg_ff) > MAX_COLUMNS) begin
         eff_cols = 8'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_cfg_ff;
      end
      if (rows_cfg_ff == 6'd0) begin
         eff_rows = 6'd1;
      end else if (32'(rows_cfg_ff) > MAX_LINES) begin
         eff_rows = 6'(MAX_LINES);
      end else begin
         eff_rows = rows_cfg_ff;
      end
   end

   assign cols_last = COL_AW'(eff_cols - 8'd1);
   assign rows_last = ROW_AW'(eff_rows - 6'd1);

   assign is_put   = req_ff.cmd == CMD_PUT;
   assign is_clear = req_ff.cmd == CMD_CLEAR;
   assign is_read  = req_ff.cmd == CMD_READ;
   assign ch_nl    = req_ff.char_code == CH_NEWLINE;
   assign ch_cr    = req_ff.char_code == CH_RETURN;
   assign ch_bs    = req_ff.char_code == CH_BACKSPACE;
   assign ch_tab   = req_ff.char_code == CH_TAB;
   assign ch_ord   = !ch_nl && !ch_cr && !ch_bs && !ch_tab;

   assign col_full   = col_ff >= eff_cols;
   assign nl_now     = is_put && (ch_nl || (ch_ord && col_full));
   assign row_inc    = 8'(row_ff) + 8'd1;
   assign scroll_now = nl_now && (row_inc >= {2'b00, eff_rows});
   assign multi_row  = eff_rows > 6'd1;
   assign tab_base   = {1'b0, col_ff[7:2], 2'b00} + TAB_STEP;
   assign tab_end    = (tab_base < {1'b0, eff_cols}) ? 8'(tab_base) : eff_cols;
   assign walk_last  = (wk_row_ff == wk_last_row_ff) && (wk_col_ff == wk_last_col_ff);

   always_comb begin
      status.is_read     = is_read;
      status.is_clear    = is_clear;
      status.tab_fill    = is_put && ch_tab && !col_full;
      status.need_scroll = scroll_now;
      status.scroll_copy = multi_row;
      status.wrap_put    = is_put && ch_ord && col_full;
      status.walk_last   = walk_last;
   end

   always_comb begin
      cols_cfg_in    = cols_cfg_ff;
      rows_cfg_in    = rows_cfg_ff;
      req_in         = cmd.load_req ? req_data : req_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      wk_row_in      = wk_row_ff;
      wk_col_in      = wk_col_ff;
      wk_last_row_in = wk_last_row_ff;
      wk_last_col_in = wk_last_col_ff;
      wk_val_in      = wk_val_ff;
      wr_en_in       = 1'b0;
      wr_addr_in     = wr_addr_ff;
      wr_src_rd_in   = 1'b0;
      wr_data_in     = wr_data_ff;
      cell_in        = cell_ff;
      rd_ok_in       = rd_ok_ff;
      rsp_in         = rsp_ff;
      rd_addr        = {ROW_AW'(req_ff.read_row), COL_AW'(req_ff.read_col)};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMNS: cols_cfg_in = csr_wdata;
            CSR_ROWS:    rows_cfg_in = csr_wdata[5:0];
            default:     cols_cfg_in = cols_cfg_ff;
         endcase
      end

      if (cmd.exec) begin
         cell_in  = CH_NUL;
         rd_ok_in = (32'(req_ff.read_row) < MAX_LINES) && (32'(req_ff.read_col) < MAX_COLUMNS);
         if (is_clear) begin
            row_in         = '0;
            col_in         = 8'd0;
            wk_row_in      = '0;
            wk_col_in      = '0;
            wk_last_row_in = rows_last;
            wk_last_col_in = cols_last;
            wk_val_in      = CH_NUL;
         end else if (is_put) begin
            if (nl_now) begin
               col_in = 8'd0;
               if (scroll_now) begin
                  row_in         = rows_last;
                  wk_row_in      = '0;
                  wk_col_in      = '0;
                  wk_last_row_in = multi_row ? ROW_AW'(eff_rows - 6'd2) : rows_last;
                  wk_last_col_in = cols_last;
                  wk_val_in      = CH_NUL;
               end else begin
                  row_in = ROW_AW'(row_inc);
               end
            end else if (ch_cr) begin
               col_in = 8'd0;
            end else if (ch_bs) begin
               if (col_ff != 8'd0) begin
                  col_in     = col_ff - 8'd1;
                  wr_en_in   = 1'b1;
                  wr_addr_in = {row_ff, COL_AW'(col_ff - 8'd1)};
                  wr_data_in = CH_NUL;
               end
            end else if (ch_tab) begin
               if (!col_full) begin
                  col_in         = tab_end;
                  wk_row_in      = row_ff;
                  wk_last_row_in = row_ff;
                  wk_col_in      = COL_AW'(col_ff);
                  wk_last_col_in = COL_AW'(tab_end - 8'd1);
                  wk_val_in      = CH_SPACE;
               end
            end else begin
               col_in     = col_ff + 8'd1;
               wr_en_in   = 1'b1;
               wr_addr_in = {row_ff, COL_AW'(col_ff)};
               wr_data_in = req_ff.char_code;
            end
         end
      end

      if (cmd.put_write) begin
         col_in     = col_ff + 8'd1;
         wr_en_in   = 1'b1;
         wr_addr_in = {row_ff, COL_AW'(col_ff)};
         wr_data_in = req_ff.char_code;
      end

      if (cmd.fill_step) begin
         wr_en_in   = 1'b1;
         wr_addr_in = {wk_row_ff, wk_col_ff};
         wr_data_in = wk_val_ff;
         if (wk_col_ff == wk_last_col_ff) begin
            wk_col_in = '0;
            wk_row_in = wk_row_ff + ROW_AW'(1);
         end else begin
            wk_col_in = wk_col_ff + COL_AW'(1);
         end
      end

      if (cmd.copy_step) begin
         rd_addr      = {wk_row_ff + ROW_AW'(1), wk_col_ff};
         wr_en_in     = 1'b1;
         wr_addr_in   = {wk_row_ff, wk_col_ff};
         wr_src_rd_in = 1'b1;
         if (walk_last) begin
            wk_row_in      = rows_last;
            wk_col_in      = '0;
            wk_last_row_in = rows_last;
            wk_last_col_in = cols_last;
            wk_val_in      = CH_NUL;
         end else if (wk_col_ff == wk_last_col_ff) begin
            wk_col_in = '0;
            wk_row_in = wk_row_ff + ROW_AW'(1);
         end else begin
            wk_col_in = wk_col_ff + COL_AW'(1);
         end
      end

      if (cmd.capture_cell) begin
         cell_in = rd_ok_ff ? rd_ff : CH_NUL;
      end

      if (cmd.load_rsp) begin
         rsp_in.cell_char      = cell_ff;
         rsp_in.cursor_row_now = 5'(row_ff);
         rsp_in.cursor_col_now = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         mem[wr_addr_ff] <= wr_src_rd_ff ? rd_ff : wr_data_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff    <= COLUMNS_RESET;
         rows_cfg_ff    <= ROWS_RESET;
         row_ff         <= '0;
         col_ff         <= 8'd0;
         wk_row_ff      <= '0;
         wk_col_ff      <= '0;
         wk_last_row_ff <= ROW_AW'(MAX_LINES - 1);
         wk_last_col_ff <= COL_AW'(MAX_COLUMNS - 1);
         wk_val_ff      <= CH_NUL;
         wr_en_ff       <= 1'b0;
      end else begin
         cols_cfg_ff    <= cols_cfg_in;
         rows_cfg_ff    <= rows_cfg_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         wk_row_ff      <= wk_row_in;
         wk_col_ff      <= wk_col_in;
         wk_last_row_ff <= wk_last_row_in;
         wk_last_col_ff <= wk_last_col_in;
         wk_val_ff      <= wk_val_in;
         wr_en_ff       <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      wr_addr_ff   <= wr_addr_in;
      wr_src_rd_ff <= wr_src_rd_in;
      wr_data_ff   <= wr_data_in;
      cell_ff      <= cell_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

>>> src/text_cell_terminal_buffer_top.sv
// ----------------------------------------------------------------------------
// text_cell_terminal_buffer_top
// Character-cell terminal buffer: a grid of byte cells with a cursor, driven
// by put-character, clear and read requests, one response per request.
// ----------------------------------------------------------------------------
// Timing: after reset the cell memory is cleared one cell per cycle, all
// MAX_LINES * MAX_COLUMNS cells (4096 by default), with req_stall high. A
// request passes the execute and done states, and no others for an ordinary
// character, return, backspace or newline without scroll; a read adds a read
// state (registered memory read), a wrap without scroll a put state, a tab a
// fill walk over its spaces, a clear a fill of rows * columns cells, a scroll
// a copy of the rows up, a fill of the last row and a put if wrapped; every
// cell moves through the single memory write port one per cycle. A finished
// response sits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_terminal_buffer_top #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_LINES   = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tctb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tctb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);
   import tctb_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   tctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tctb_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_LINES   (MAX_LINES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

>>> src/tctb_checker.sv
// ----------------------------------------------------------------------------
// tctb_checker
// Port-level checks of the terminal buffer: responses match accepted
// requests in count, and the response channel behaves after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tctb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tctb_pkg::rsp_type rsp_data
);
   import tctb_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind text_cell_terminal_buffer_top tctb_checker u_checker (.*);

`default_nettype wire

>>> tb/text_cell_terminal_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// text_cell_terminal_buffer_top_tb
// Self-checking bench for the character-cell terminal buffer. A clocked
// driver feeds put, clear, read and unused-command requests from a queue. A
// clocked monitor predicts each accepted request against a local screen and
// cursor model and checks every response field in order. Geometry registers
// are reprogrammed between phases across in-range, extreme and out-of-range
// values, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_cell_terminal_buffer_top_tb;

   import tctb_pkg::*;

   localparam int SCREEN_COLS = 128;
   localparam int SCREEN_ROWS = 32;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_COLUMNS;
   logic [7:0] csr_wdata = '0;

   req_type command_queue[$];
   rsp_type cursor_reports_due[$];

   logic [7:0] screen_cells [0:SCREEN_ROWS-1][0:SCREEN_COLS-1];
   int         cur_row;
   int         cur_col;
   logic [7:0] cfg_columns;
   logic [5:0] cfg_rows;

   int send_gap_pct = 11;
   int rsp_hold_pct = 57;
   int error_count  = 0;
   int cycle_count  = 0;

   text_cell_terminal_buffer_top #(
      .MAX_COLUMNS(SCREEN_COLS),
      .MAX_LINES  (SCREEN_ROWS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int used_columns();
      if (cfg_columns < 1) return 1;
      if (cfg_columns > SCREEN_COLS) return SCREEN_COLS;
      return int'(cfg_columns);
   endfunction

   function automatic int used_rows();
      if (cfg_rows < 1) return 1;
      if (cfg_rows > SCREEN_ROWS) return SCREEN_ROWS;
      return int'(cfg_rows);
   endfunction

   // advance to the next row, scrolling the area in use past its last row
   function automatic void line_feed();
      int nrows;
      int ncols;
      int r;
      int c;
      nrows = used_rows();
      ncols = used_columns();
      cur_col = 0;
      cur_row++;
      if (cur_row >= nrows) begin
         for (r = 0; r + 1 < nrows; r++)
            for (c = 0; c < ncols; c++)
               screen_cells[r][c] = screen_cells[r+1][c];
         for (c = 0; c < ncols; c++)
            screen_cells[nrows-1][c] = CH_NUL;
         cur_row = nrows - 1;
      end
   endfunction

   function automatic rsp_type predict_cursor_report(req_type item);
      rsp_type report;
      int      ncols;
      int      nrows;
      int      fill;
      int      r;
      int      c;
      ncols = used_columns();
      nrows = used_rows();
      report.cell_char = CH_NUL;
      case (item.cmd)
         CMD_PUT: begin
            if (item.char_code == CH_NEWLINE) begin
               line_feed();
            end else if (item.char_code == CH_RETURN) begin
               cur_col = 0;
            end else if (item.char_code == CH_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen_cells[cur_row][cur_col] = CH_NUL;
               end
            end else if (item.char_code == CH_TAB) begin
               fill = int'(TAB_STEP) - (cur_col % int'(TAB_STEP));
               for (c = 0; c < fill && cur_col < ncols; c++) begin
                  screen_cells[cur_row][cur_col] = CH_SPACE;
                  cur_col++;
               end
            end else begin
               if (cur_col >= ncols) line_feed();
               screen_cells[cur_row][cur_col] = item.char_code;
               cur_col++;
            end
         end
         CMD_CLEAR: begin
            for (r = 0; r < nrows; r++)
               for (c = 0; c < ncols; c++)
                  screen_cells[r][c] = CH_NUL;
            cur_row = 0;
            cur_col = 0;
         end
         CMD_READ: begin
            report.cell_char = screen_cells[item.read_row][item.read_col];
         end
         default: ;
      endcase
      report.cursor_row_now = cur_row[4:0];
      report.cursor_col_now = cur_col[7:0];
      return report;
   endfunction

   function automatic req_type make_command(logic [1:0] cmd, logic [7:0] ch,
                                            logic [4:0] row, logic [6:0] col);
      req_type item;
      item.cmd       = cmd;
      item.char_code = ch;
      item.read_row  = row;
      item.read_col  = col;
      return item;
   endfunction

   // mostly text with control bytes, some reads, rare clears and unused codes
   function automatic req_type random_command();
      req_type item;
      int      pick;
      item = make_command(CMD_PUT, 8'($urandom_range(255)), 5'($urandom_range(31)),
                          7'($urandom_range(127)));
      pick = $urandom_range(99);
      if (pick < 50) item.char_code = 8'($urandom_range(126, 32));
      else if (pick < 57) item.char_code = CH_NEWLINE;
      else if (pick < 61) item.char_code = CH_RETURN;
      else if (pick < 67) item.char_code = CH_BACKSPACE;
      else if (pick < 73) item.char_code = CH_TAB;
      else if (pick < 78) ;
      else if (pick < 81) item.cmd = CMD_CLEAR;
      else if (pick < 97) begin
         item.cmd = CMD_READ;
         if ($urandom_range(3) != 0) begin
            item.read_row = 5'($urandom_range(used_rows() - 1));
            item.read_col = 7'($urandom_range(used_columns() - 1));
         end
      end else begin
         item.cmd = CMD_UNUSED;
      end
      return item;
   endfunction

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COLUMNS) cfg_columns = value;
      else cfg_rows = value[5:0];
   endtask

   task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, rows);
   endtask

   task automatic queue_random(input int count);
      repeat (count) command_queue.push_back(random_command());
   endtask

   // hold the sender until every response is back, then let the block settle
   task automatic drain();
      while (command_queue.size() != 0 || req_valid || cursor_reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (command_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_data  <= command_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (cursor_reports_due.size() == 0) begin
               $error("response with none outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = cursor_reports_due.pop_front();
               if (rsp_data.cell_char !== want.cell_char) begin
                  $error("cell_char: expected %0d, actual %0d",
                         want.cell_char, rsp_data.cell_char);
                  error_count++;
               end
               if (rsp_data.cursor_row_now !== want.cursor_row_now) begin
                  $error("cursor_row_now: expected %0d, actual %0d",
                         want.cursor_row_now, rsp_data.cursor_row_now);
                  error_count++;
               end
               if (rsp_data.cursor_col_now !== want.cursor_col_now) begin
                  $error("cursor_col_now: expected %0d, actual %0d",
                         want.cursor_col_now, rsp_data.cursor_col_now);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            cursor_reports_due.push_back(predict_cursor_report(req_data));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < SCREEN_ROWS; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            screen_cells[r][c] = CH_NUL;
      cur_row     = 0;
      cur_col     = 0;
      cfg_columns = COLUMNS_RESET;
      cfg_rows    = ROWS_RESET;

      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, 8'd65, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, 8'd255, 5'd31, 7'd127));
      command_queue.push_back(make_command(CMD_PUT, CH_NUL, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd0, 7'd1));
      command_queue.push_back(make_command(CMD_READ, 8'd255, 5'd0, 7'd2));
      command_queue.push_back(make_command(CMD_PUT, CH_TAB, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, CH_TAB, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd0, 7'd5));
      command_queue.push_back(make_command(CMD_PUT, CH_RETURN, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_PUT, 8'd122, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_UNUSED, 8'd255, 5'd31, 7'd127));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd31, 7'd127));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd1, 7'd0));
      command_queue.push_back(make_command(CMD_CLEAR, 8'd0, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd0, 7'd0));
      command_queue.push_back(make_command(CMD_READ, 8'd0, 5'd1, 7'd0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      drain();

      // sender rarely idle, receiver often stalled
      set_geometry(8'd8, 8'hC4);
      queue_random(150);
      drain();
      set_geometry(8'd1, 8'd1);
      queue_random(60);
      drain();
      set_geometry(8'd0, 8'd0);
      queue_random(40);
      drain();
      set_geometry(8'd255, 8'd63);
      repeat (31) command_queue.push_back(make_command(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
      repeat (120)
         command_queue.push_back(make_command(CMD_PUT, 8'($urandom_range(126, 33)),
                                              5'd0, 7'd0));
      queue_random(25);
      drain();

      // sender often idle, receiver rarely stalled
      send_gap_pct = 57;
      rsp_hold_pct = 11;
      set_geometry(8'd16, 8'd8);
      queue_random(200);
      drain();
      set_geometry(8'd5, 8'd3);
      queue_random(150);
      drain();
      set_geometry(8'd128, 8'd2);
      queue_random(60);
      drain();
      set_geometry(8'd3, 8'd32);
      queue_random(100);
      drain();

      // no idling on either side
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      set_geometry(8'd12, 8'd6);
      queue_random(200);
      drain();
      set_geometry(8'd7, 8'd63);
      queue_random(100);
      drain();
      set_geometry(8'd200, 8'd1);
      queue_random(40);
      drain();
      set_geometry(8'd10, 8'd5);
      queue_random(200);
      drain();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
